>>> rtl/tts_pkg.sv
// tts_pkg: shared constants and types for the tick task scheduler.
// Used by tick_task_scheduler, tts_addsub, tts_checker and tick_task_scheduler_tb. No dependencies.
`default_nettype none

package tts_pkg;

   localparam int SLOTS_DEF = 8;

   localparam int OP_W      = 2;
   localparam int TASK_W    = 8;
   localparam int IVL_W     = 32;
   localparam int TIME_W    = 64;
   localparam int KIND_W    = 3;
   localparam int SLOT_W    = 3;

   // request opcodes
   localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
   localparam logic [OP_W-1:0] OP_SUBMIT = 2'd1;
   localparam logic [OP_W-1:0] OP_SCAN   = 2'd2;

   // response kinds
   localparam logic [KIND_W-1:0] KIND_TICK  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_OK    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_FULL  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_FIRED = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DONE  = 3'd4;

   // one slot table entry as stored in the RAM
   typedef struct packed {
      logic [TASK_W-1:0] task_id;
      logic              rep;
      logic [IVL_W-1:0]  ivl;
      logic [TIME_W-1:0] due;
   } slot_entry_type;

   localparam int ENTRY_W = $bits(slot_entry_type);

   // operand set for the shared adder
   typedef struct packed {
      logic [TIME_W-1:0] a;
      logic [TIME_W-1:0] b;
      logic              sub;
   } alu_ctrl_type;

endpackage

`default_nettype wire

>>> rtl/tts_ram.sv
// tts_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tts_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 8,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> rtl/tts_addsub.sv
// tts_addsub: shared 64-bit add/subtract unit with carry out.
// Depends on tts_pkg (alu_ctrl_type, TIME_W).
`default_nettype none

module tts_addsub (
   input  wire tts_pkg::alu_ctrl_type       ctrl,
   output logic [tts_pkg::TIME_W-1:0]        sum,
   output logic                              carry
);

   logic [tts_pkg::TIME_W-1:0] b_eff;

   // subtract as a + ~b + 1; carry out set means a >= b
   assign b_eff = ctrl.sub ? ~ctrl.b : ctrl.b;
   assign {carry, sum} = {1'b0, ctrl.a} + {1'b0, b_eff}
                         + (tts_pkg::TIME_W + 1)'(ctrl.sub);

endmodule

`default_nettype wire

>>> rtl/tick_task_scheduler.sv
// tick_task_scheduler: millisecond counter plus a slot table of timed tasks.
// Depends on tts_pkg, tts_ram and tts_addsub.
//
//   channel  ports              transfer when          direction
//   -------  -----------------  ---------------------  ---------
//   request  start, busy, req_* start high, busy low   in
//   response rsp_strobe, rsp_*  rsp_strobe high        out
//
// Steps: a tick goes through the tick state, then its response is registered.
// A submit walks the slots from index 0 to the lowest free slot (to the last
// slot when the table is full). A scan walks every slot: a free slot is
// skipped, a valid one is read and compared, a due repeating one also has its
// due advanced; the end state gives the closing response. The walk is bound
// by one RAM address and one shared 65-bit adder (due compare and due update).
// Reset: synchronous, clears the counter, the valid bits and the sequencer;
// the slot RAM is not cleared, its entries are only read behind a valid bit.
// Stalls: the response side cannot stall; busy stays high until the last
// response of a command is registered, and a new command may transfer in
// the cycle its last response is shown.
`default_nettype none

module tick_task_scheduler #(
   parameter int SLOTS = tts_pkg::SLOTS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [tts_pkg::OP_W-1:0]      req_op,
   input  wire logic [tts_pkg::TASK_W-1:0]    req_task_id,
   input  wire logic [tts_pkg::IVL_W-1:0]     req_interval,
   input  wire logic                          req_repeating,
   output logic                               rsp_strobe,
   output logic      [tts_pkg::KIND_W-1:0]    rsp_kind,
   output logic      [tts_pkg::SLOT_W-1:0]    rsp_slot,
   output logic      [tts_pkg::TASK_W-1:0]    rsp_fired_task,
   output logic      [tts_pkg::TIME_W-1:0]    rsp_now_ms,
   output logic                               rsp_last
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);

   // sequencer states
   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_TICK     = 3'd1;
   localparam logic [2:0] S_SUB      = 3'd2;
   localparam logic [2:0] S_SCAN_RD  = 3'd3;
   localparam logic [2:0] S_SCAN_CMP = 3'd4;
   localparam logic [2:0] S_SCAN_ADV = 3'd5;
   localparam logic [2:0] S_SCAN_END = 3'd6;

   logic [2:0]                   state_ff, state_in;
   logic [IDX_W-1:0]             idx_ff, idx_in;
   logic [SLOTS-1:0]             valid_ff, valid_in;
   logic [SLOTS-1:0]             pend_ff, pend_in;     // shifting copy of valid bits
   logic [tts_pkg::TIME_W-1:0]   now_ff, now_in;

   // request payload held for the submit walk
   logic [tts_pkg::TASK_W-1:0]   task_ff;
   logic [tts_pkg::IVL_W-1:0]    ivl_ff;
   logic                         rep_ff;

   logic                         rsp_strobe_ff, rsp_strobe_in;
   logic [tts_pkg::KIND_W-1:0]   rsp_kind_ff, rsp_kind_in;
   logic [tts_pkg::SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [tts_pkg::TASK_W-1:0]   rsp_task_ff, rsp_task_in;
   logic                         rsp_last_ff, rsp_last_in;

   tts_pkg::alu_ctrl_type        alu_ctrl;
   logic [tts_pkg::TIME_W-1:0]   alu_sum;
   logic                         alu_carry;

   logic                         ram_wr_en;
   logic                         ram_rd_en;
   tts_pkg::slot_entry_type      ram_wdata;
   tts_pkg::slot_entry_type      ram_rdata;
   logic [tts_pkg::ENTRY_W-1:0]  ram_rdata_raw;

   logic                         last_slot;

   tts_addsub u_addsub (
      .ctrl  (alu_ctrl),
      .sum   (alu_sum),
      .carry (alu_carry)
   );

   tts_ram #(
      .WIDTH  (tts_pkg::ENTRY_W),
      .DEPTH  (SLOTS),
      .ADDR_W (IDX_W)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (idx_ff),
      .wr_data (ram_wdata),
      .rd_en   (ram_rd_en),
      .rd_addr (idx_ff),
      .rd_data (ram_rdata_raw)
   );

   assign ram_rdata = tts_pkg::slot_entry_type'(ram_rdata_raw);
   assign last_slot = (idx_ff == IDX_LAST);

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      valid_in      = valid_ff;
      pend_in       = pend_ff;
      now_in        = now_ff;
      rsp_strobe_in = 1'b0;
      rsp_kind_in   = tts_pkg::KIND_TICK;
      rsp_slot_in   = '0;
      rsp_task_in   = '0;
      rsp_last_in   = 1'b0;
      alu_ctrl.a    = now_ff;
      alu_ctrl.b    = tts_pkg::TIME_W'(1);
      alu_ctrl.sub  = 1'b0;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;
      ram_wdata     = ram_rdata;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               idx_in  = '0;
               pend_in = valid_ff;
               case (req_op)
                  tts_pkg::OP_TICK:   state_in = S_TICK;
                  tts_pkg::OP_SUBMIT: state_in = S_SUB;
                  tts_pkg::OP_SCAN:   state_in = S_SCAN_RD;
                  default:            state_in = S_IDLE;  // unused op: no response
               endcase
            end
         end

         S_TICK: begin
            now_in        = alu_sum;
            rsp_strobe_in = 1'b1;
            rsp_kind_in   = tts_pkg::KIND_TICK;
            rsp_last_in   = 1'b1;
            state_in      = S_IDLE;
         end

         S_SUB: begin
            alu_ctrl.b = tts_pkg::TIME_W'(ivl_ff);
            if (!pend_ff[0]) begin
               ram_wr_en         = 1'b1;
               ram_wdata.task_id = task_ff;
               ram_wdata.rep     = rep_ff;
               ram_wdata.ivl     = ivl_ff;
               ram_wdata.due     = alu_sum;
               valid_in[idx_ff]  = 1'b1;
               rsp_strobe_in     = 1'b1;
               rsp_kind_in       = tts_pkg::KIND_OK;
               rsp_slot_in       = tts_pkg::SLOT_W'(idx_ff);
               rsp_last_in       = 1'b1;
               state_in          = S_IDLE;
            end else if (last_slot) begin
               rsp_strobe_in = 1'b1;
               rsp_kind_in   = tts_pkg::KIND_FULL;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end else begin
               idx_in  = idx_ff + IDX_W'(1);
               pend_in = pend_ff >> 1;
            end
         end

         S_SCAN_RD: begin
            if (pend_ff[0]) begin
               ram_rd_en = 1'b1;
               state_in  = S_SCAN_CMP;
            end else if (last_slot) begin
               state_in = S_SCAN_END;
            end else begin
               idx_in  = idx_ff + IDX_W'(1);
               pend_in = pend_ff >> 1;
            end
         end

         S_SCAN_CMP: begin
            // now - due, no borrow means the slot is due
            alu_ctrl.b   = ram_rdata.due;
            alu_ctrl.sub = 1'b1;
            if (alu_carry && ram_rdata.rep) begin
               state_in = S_SCAN_ADV;
            end else begin
               if (alu_carry) begin
                  valid_in[idx_ff] = 1'b0;
                  rsp_strobe_in    = 1'b1;
                  rsp_kind_in      = tts_pkg::KIND_FIRED;
                  rsp_slot_in      = tts_pkg::SLOT_W'(idx_ff);
                  rsp_task_in      = ram_rdata.task_id;
               end
               if (last_slot) begin
                  state_in = S_SCAN_END;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  pend_in  = pend_ff >> 1;
                  state_in = S_SCAN_RD;
               end
            end
         end

         S_SCAN_ADV: begin
            alu_ctrl.a    = ram_rdata.due;
            alu_ctrl.b    = tts_pkg::TIME_W'(ram_rdata.ivl);
            ram_wr_en     = 1'b1;
            ram_wdata.due = alu_sum;
            rsp_strobe_in = 1'b1;
            rsp_kind_in   = tts_pkg::KIND_FIRED;
            rsp_slot_in   = tts_pkg::SLOT_W'(idx_ff);
            rsp_task_in   = ram_rdata.task_id;
            if (last_slot) begin
               state_in = S_SCAN_END;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               pend_in  = pend_ff >> 1;
               state_in = S_SCAN_RD;
            end
         end

         S_SCAN_END: begin
            rsp_strobe_in = 1'b1;
            rsp_kind_in   = tts_pkg::KIND_DONE;
            rsp_last_in   = 1'b1;
            state_in      = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         idx_ff        <= '0;
         valid_ff      <= '0;
         pend_ff       <= '0;
         now_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         valid_ff      <= valid_in;
         pend_ff       <= pend_in;
         now_ff        <= now_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (start && (state_ff == S_IDLE)) begin
         task_ff <= req_task_id;
         ivl_ff  <= req_interval;
         rep_ff  <= req_repeating;
      end
      rsp_kind_ff <= rsp_kind_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_task_ff <= rsp_task_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_fired_task = rsp_task_ff;
   assign rsp_last       = rsp_last_ff;
   // the counter only moves in the tick state, so it is stable under every response
   assign rsp_now_ms     = now_ff;

endmodule

`default_nettype wire

>>> rtl/tts_checker.sv
// tts_checker: port-level assertions for tick_task_scheduler, bound to it below.
// Depends on tts_pkg and tick_task_scheduler.
`default_nettype none

module tts_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          start,
   input wire logic                          busy,
   input wire logic [tts_pkg::OP_W-1:0]      req_op,
   input wire logic                          rsp_strobe,
   input wire logic [tts_pkg::KIND_W-1:0]    rsp_kind,
   input wire logic [tts_pkg::TASK_W-1:0]    rsp_fired_task,
   input wire logic [tts_pkg::TIME_W-1:0]    rsp_now_ms,
   input wire logic                          rsp_last
);

   logic tick_xfer;
   assign tick_xfer = start && !busy && (req_op == tts_pkg::OP_TICK);

   // a tick answers through the tick state and the response register, as a closing response
   a_tick_latency: assert property (@(posedge clock) disable iff (reset)
      tick_xfer |=> ##1 (rsp_strobe && rsp_last && (rsp_kind == tts_pkg::KIND_TICK)))
      else $error("tick response missing or late");

   // a tick response shows the counter one above the cycle before
   a_tick_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_kind == tts_pkg::KIND_TICK)) |->
         (rsp_now_ms == $past(rsp_now_ms) + tts_pkg::TIME_W'(1)))
      else $error("tick did not advance counter by one");

   // the closing response frees the block; earlier ones are fired tasks of a live scan
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last) |-> !busy)
      else $error("busy still high at closing response");

   a_mid_fired: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |-> (busy && (rsp_kind == tts_pkg::KIND_FIRED)))
      else $error("non-final response outside a scan");

   a_task_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_kind != tts_pkg::KIND_FIRED)) |-> (rsp_fired_task == '0))
      else $error("task id on a non-fired response");

endmodule

bind tick_task_scheduler tts_checker u_tts_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_op         (req_op),
   .rsp_strobe     (rsp_strobe),
   .rsp_kind       (rsp_kind),
   .rsp_fired_task (rsp_fired_task),
   .rsp_now_ms     (rsp_now_ms),
   .rsp_last       (rsp_last)
);

`default_nettype wire

>>> sim/tick_task_scheduler_tb.sv
`timescale 1ns / 1ps
// tick_task_scheduler_tb: self-checking bench for the tick task scheduler.
// Depends on tts_pkg and tick_task_scheduler; scoreboard class lives in here.

module tick_task_scheduler_tb;

   localparam int N_SLOTS = tts_pkg::SLOTS_DEF;
   localparam logic [tts_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int N_RANDOM = 372;
   localparam int TAIL_CYCLES = 40;
   // slots due further out than this are treated as "never fires" for stimulus shaping
   localparam logic [tts_pkg::TIME_W-1:0] PARK_HORIZON = 64'd100000;

   // one response as the block shows it
   typedef struct packed {
      logic [tts_pkg::KIND_W-1:0] kind;
      logic [tts_pkg::SLOT_W-1:0] slot;
      logic [tts_pkg::TASK_W-1:0] fired_task;
      logic [tts_pkg::TIME_W-1:0] now_ms;
      logic                       last;
   } sched_rsp_type;

   // Scoreboard: mirrors the counter and slot table, queues the responses
   // each command transfer implies, and checks them in order.
   class sched_scoreboard;
      logic [tts_pkg::TIME_W-1:0] now_ms;
      bit                         valid[N_SLOTS];
      logic [tts_pkg::TASK_W-1:0] task_id[N_SLOTS];
      bit                         rep[N_SLOTS];
      logic [tts_pkg::IVL_W-1:0]  ivl[N_SLOTS];
      logic [tts_pkg::TIME_W-1:0] due[N_SLOTS];
      sched_rsp_type              pending_rsp[$];
      int                         fails;

      function new();
         now_ms = '0;
         fails  = 0;
         foreach (valid[i]) begin
            valid[i] = 0;
            rep[i] = 0;
            task_id[i] = '0;
            ivl[i] = '0;
            due[i] = '0;
         end
      endfunction

      function void queue_rsp(logic [tts_pkg::KIND_W-1:0] kind, int slot_idx,
                              logic [tts_pkg::TASK_W-1:0] tid, logic last);
         sched_rsp_type r;
         r.kind       = kind;
         r.slot       = slot_idx[tts_pkg::SLOT_W-1:0];
         r.fired_task = tid;
         r.now_ms     = now_ms;
         r.last       = last;
         pending_rsp.push_back(r);
      endfunction

      // update the mirror for one accepted command
      function void note_command(logic [tts_pkg::OP_W-1:0] op,
                                 logic [tts_pkg::TASK_W-1:0] tid,
                                 logic [tts_pkg::IVL_W-1:0] interval,
                                 logic repeating);
         int free_idx;
         free_idx = -1;
         case (op)
            tts_pkg::OP_TICK: begin
               now_ms = now_ms + 1;
               queue_rsp(tts_pkg::KIND_TICK, 0, '0, 1'b1);
            end
            tts_pkg::OP_SUBMIT: begin
               for (int i = N_SLOTS - 1; i >= 0; i--)
                  if (!valid[i]) free_idx = i;
               if (free_idx < 0) begin
                  queue_rsp(tts_pkg::KIND_FULL, 0, '0, 1'b1);
               end else begin
                  valid[free_idx]   = 1;
                  task_id[free_idx] = tid;
                  rep[free_idx]     = repeating;
                  ivl[free_idx]     = interval;
                  due[free_idx]     = now_ms + {32'd0, interval};
                  queue_rsp(tts_pkg::KIND_OK, free_idx, '0, 1'b1);
               end
            end
            tts_pkg::OP_SCAN: begin
               for (int i = 0; i < N_SLOTS; i++) begin
                  if (valid[i] && now_ms >= due[i]) begin
                     if (rep[i]) due[i] = due[i] + {32'd0, ivl[i]};
                     else valid[i] = 0;
                     queue_rsp(tts_pkg::KIND_FIRED, i, task_id[i], 1'b0);
                  end
               end
               queue_rsp(tts_pkg::KIND_DONE, 0, '0, 1'b1);
            end
            default: ;  // unused op: no state change, no response
         endcase
      endfunction

      function void check_rsp(sched_rsp_type got);
         sched_rsp_type exp;
         if (pending_rsp.size() == 0) begin
            $error("unexpected response: kind %0d slot %0d", got.kind, got.slot);
            fails++;
            return;
         end
         exp = pending_rsp.pop_front();
         if (got.kind !== exp.kind) begin
            $error("rsp_kind: expected %0d, got %0d", exp.kind, got.kind);
            fails++;
         end
         if (got.slot !== exp.slot) begin
            $error("rsp_slot: expected %0d, got %0d", exp.slot, got.slot);
            fails++;
         end
         if (got.fired_task !== exp.fired_task) begin
            $error("rsp_fired_task: expected %0d, got %0d", exp.fired_task,
                   got.fired_task);
            fails++;
         end
         if (got.now_ms !== exp.now_ms) begin
            $error("rsp_now_ms: expected %0d, got %0d", exp.now_ms, got.now_ms);
            fails++;
         end
         if (got.last !== exp.last) begin
            $error("rsp_last: expected %0d, got %0d", exp.last, got.last);
            fails++;
         end
      endfunction

      function int outstanding();
         return pending_rsp.size();
      endfunction

      function int repeat_count();
         int n;
         n = 0;
         foreach (valid[i]) if (valid[i] && rep[i]) n++;
         return n;
      endfunction

      // slots that will not fire within any realistic run length
      function int parked_count();
         int n;
         n = 0;
         foreach (valid[i]) if (valid[i] && due[i] > now_ms + PARK_HORIZON) n++;
         return n;
      endfunction
   endclass

   logic                         clock;
   logic                         reset;
   logic                         start;
   logic                         busy;
   logic [tts_pkg::OP_W-1:0]     req_op;
   logic [tts_pkg::TASK_W-1:0]   req_task_id;
   logic [tts_pkg::IVL_W-1:0]    req_interval;
   logic                         req_repeating;
   logic                         rsp_strobe;
   logic [tts_pkg::KIND_W-1:0]   rsp_kind;
   logic [tts_pkg::SLOT_W-1:0]   rsp_slot;
   logic [tts_pkg::TASK_W-1:0]   rsp_fired_task;
   logic [tts_pkg::TIME_W-1:0]   rsp_now_ms;
   logic                         rsp_last;

   sched_scoreboard sb = new();

   tick_task_scheduler #(
      .SLOTS(N_SLOTS)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_op         (req_op),
      .req_task_id    (req_task_id),
      .req_interval   (req_interval),
      .req_repeating  (req_repeating),
      .rsp_strobe     (rsp_strobe),
      .rsp_kind       (rsp_kind),
      .rsp_slot       (rsp_slot),
      .rsp_fired_task (rsp_fired_task),
      .rsp_now_ms     (rsp_now_ms),
      .rsp_last       (rsp_last)
   );

   // 12 ns clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Response monitor: each response holds the strobe for exactly one cycle and cannot be held
   // off, so every rising edge with the strobe up is one transfer.
   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         sb.check_rsp({rsp_kind, rsp_slot, rsp_fired_task, rsp_now_ms, rsp_last});
   end

   // Present one command from a falling edge and hold it until a rising edge
   // sees start high with busy low. Leaves start high; the caller either
   // follows with the next command or idles, so start is assigned once per edge.
   task automatic send_cmd(logic [tts_pkg::OP_W-1:0] op,
                           logic [tts_pkg::TASK_W-1:0] tid,
                           logic [tts_pkg::IVL_W-1:0] interval, logic repeating);
      start         <= 1'b1;
      req_op        <= op;
      req_task_id   <= tid;
      req_interval  <= interval;
      req_repeating <= repeating;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_command(op, tid, interval, repeating);
      @(negedge clock);
   endtask

   // Drop start and idle for the length that n gives; the payload ports carry junk meanwhile.
   task automatic idle_cycles(int n);
      if (n > 0) begin
         start         <= 1'b0;
         req_op        <= 2'($urandom);
         req_task_id   <= 8'($urandom);
         req_interval  <= $urandom;
         req_repeating <= 1'($urandom);
         repeat (n) @(negedge clock);
      end
   endtask

   // Hold off until every queued response has been seen.
   task automatic drain_responses();
      start <= 1'b0;
      @(negedge clock);
      while (sb.outstanding() > 0) @(negedge clock);
   endtask

   // Random command, shaped so the table keeps turning over: repeating and
   // far-off slots never free up, so only a few of each are allowed to live.
   task automatic send_random_cmd(output bit counted);
      int                        pick;
      logic [tts_pkg::OP_W-1:0]  op;
      logic [tts_pkg::IVL_W-1:0] interval;
      logic                      repeating;
      pick      = $urandom_range(0, 99);
      repeating = 1'b0;
      interval  = '0;
      counted   = 1;
      if (pick < 4) begin
         op = OP_UNUSED;
         counted = 0;
      end else if (pick < 38) begin
         op = tts_pkg::OP_TICK;
      end else if (pick < 70) begin
         op = tts_pkg::OP_SUBMIT;
         if (sb.repeat_count() < 4 && $urandom_range(0, 3) == 0) begin
            repeating = 1'b1;
            interval  = $urandom_range(0, 6);
         end else if (sb.parked_count() < 3 && $urandom_range(0, 39) == 0) begin
            interval = $urandom | 32'h8000_0000;
         end else begin
            interval = $urandom_range(0, 8);
         end
      end else begin
         op = tts_pkg::OP_SCAN;
      end
      send_cmd(op, 8'($urandom), interval, repeating);
   endtask

   initial begin
      bit counted;
      int done_items;

      reset         = 1'b1;
      start         = 1'b0;
      req_op        = tts_pkg::OP_TICK;
      req_task_id   = '0;
      req_interval  = '0;
      req_repeating = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty scan, far-off and zero-interval repeaters, fill the
      // table, hit table full, scans that fire and free, the unused op
      send_cmd(tts_pkg::OP_SCAN,   8'h00, 32'h0,         1'b0);
      send_cmd(tts_pkg::OP_TICK,   8'h00, 32'h0,         1'b0);
      send_cmd(tts_pkg::OP_SUBMIT, 8'hFF, 32'hFFFF_FFFF, 1'b1);
      send_cmd(tts_pkg::OP_SUBMIT, 8'h00, 32'h0,         1'b1);
      send_cmd(tts_pkg::OP_SCAN,   8'h00, 32'h0,         1'b0);
      for (int k = 0; k < N_SLOTS - 2; k++)
         send_cmd(tts_pkg::OP_SUBMIT, 8'h10 + 8'(k), 32'(k % 3), 1'b0);
      send_cmd(tts_pkg::OP_SUBMIT, 8'hEE, 32'h1,         1'b0);  // table full
      send_cmd(tts_pkg::OP_SCAN,   8'h00, 32'h0,         1'b0);
      send_cmd(tts_pkg::OP_TICK,   8'h00, 32'h0,         1'b0);
      send_cmd(tts_pkg::OP_TICK,   8'h00, 32'h0,         1'b0);
      send_cmd(tts_pkg::OP_SCAN,   8'h00, 32'h0,         1'b0);
      send_cmd(OP_UNUSED,          8'hFF, 32'hFFFF_FFFF, 1'b1);
      drain_responses();
      send_cmd(tts_pkg::OP_SCAN,   8'h00, 32'h0,         1'b0);
      send_cmd(tts_pkg::OP_SUBMIT, 8'h5A, 32'h1,         1'b0);
      send_cmd(tts_pkg::OP_TICK,   8'h00, 32'h0,         1'b0);
      send_cmd(tts_pkg::OP_SCAN,   8'h00, 32'h0,         1'b0);

      // random: back-to-back stretch in the middle, a full drain at item 300
      done_items = 0;
      while (done_items < N_RANDOM) begin
         if ((done_items < 150 || done_items >= 260) && $urandom_range(0, 99) < 27)
            idle_cycles($urandom_range(1, 5));
         if (done_items == 300) drain_responses();
         send_random_cmd(counted);
         if (counted) done_items++;
      end
      start <= 1'b0;

      while (sb.outstanding() > 0) @(posedge clock);
      // quiet tail to catch any stray response
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.fails == 0 && sb.outstanding() == 0)
         $display("tick_task_scheduler_tb OK");
      else
         $display("tick_task_scheduler_tb NOT OK");
      $finish;
   end

   // watchdog at 5 ms, far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("tick_task_scheduler_tb NOT OK");
      $finish;
   end

endmodule

>>> files.f
rtl/tts_pkg.sv
rtl/tts_ram.sv
rtl/tts_addsub.sv
rtl/tick_task_scheduler.sv
rtl/tts_checker.sv
sim/tick_task_scheduler_tb.sv
